// ===== rtl/core/ssoe_pkg.sv =====
// Shared types and constants for the subset set-operation engine.
package ssoe_pkg;

  localparam int unsigned DEST_MAX_DEF = 1024;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned WORD_BITS_W  = 5;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned VALUE_W      = 10;
  localparam int unsigned ELEM_W       = 10;
  localparam int unsigned ERR_W        = 2;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned DSIZE_W      = 11;
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned PDATA_W      = 32;
  localparam logic [DSIZE_W-1:0] DSIZE_RST = 11'd1024;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_FETCH  = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  typedef enum logic [OP_W-1:0] {
    OP_UNION = 2'd0,
    OP_INTER = 2'd1,
    OP_DIFF  = 2'd2,
    OP_COMPL = 2'd3
  } op_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_DUP   = 2'd1,
    ERR_RANGE = 2'd2
  } err_e;

  typedef enum logic {
    REG_OP_SELECT = 1'b0,
    REG_DEST_SIZE = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_LOAD  = 3'd1,
    ST_SCAN  = 3'd2,
    ST_RESP  = 3'd3,
    ST_SWEEP = 3'd4
  } state_e;

  typedef struct packed {
    op_e                op_select;
    logic [DSIZE_W-1:0] dest_size;
  } cfg_t;

endpackage

// ===== rtl/core/ssoe_if.sv =====
// Valid/ready stream interfaces for the item and result channels.
interface ssoe_in_if;
  logic                             valid;
  logic                             ready;
  logic [ssoe_pkg::KIND_W-1:0]      kind;
  logic [ssoe_pkg::VALUE_W-1:0]     value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface ssoe_out_if;
  logic                             valid;
  logic                             ready;
  logic [ssoe_pkg::ELEM_W-1:0]      element;
  logic                             element_valid;
  logic                             done_res;
  logic [ssoe_pkg::ERR_W-1:0]       error;

  modport source (output valid, element, element_valid, done_res, error, input ready);
  modport sink   (input valid, element, element_valid, done_res, error, output ready);
endinterface

// ===== rtl/core/ssoe_apb_regs.sv =====
// APB configuration registers: op_select and dest_size.
module ssoe_apb_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ssoe_pkg::PADDR_W-1:0]   paddr,
  input  logic [ssoe_pkg::PDATA_W-1:0]   pwdata,
  output logic [ssoe_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output ssoe_pkg::cfg_t                 cfg_o
);

  ssoe_pkg::cfg_t   cfg_q, cfg_d;
  ssoe_pkg::reg_e   reg_sel;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_sel = ssoe_pkg::reg_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        ssoe_pkg::REG_OP_SELECT:
          cfg_d.op_select = ssoe_pkg::op_e'(pwdata[ssoe_pkg::OP_W-1:0]);
        ssoe_pkg::REG_DEST_SIZE:
          cfg_d.dest_size = pwdata[ssoe_pkg::DSIZE_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ssoe_pkg::REG_OP_SELECT:
        prdata = ssoe_pkg::PDATA_W'(cfg_q.op_select);
      ssoe_pkg::REG_DEST_SIZE:
        prdata = ssoe_pkg::PDATA_W'(cfg_q.dest_size);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.op_select <= ssoe_pkg::OP_UNION;
      cfg_q.dest_size <= ssoe_pkg::DSIZE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/subset_set_operation_engine.sv =====
// Subset set-operation engine: two membership bitmaps in a word memory, scanned on fetch.
//
// Usage: item_i carries (kind, value); every accepted item gives exactly one
// transaction on result_o (element, element_valid, done_res, error).
// Kinds: load A, load B, fetch next member of the selected set, clear.
// Set A and set B share one memory, one row of 32 A bits and 32 B bits per row.
// Steps from accept to result valid, receiver ready:
//   load in range      read row, write row, present result
//   load out of range  present result
//   fetch              read the row at the cursor, scan one row per cycle (set by
//                      the single read port), present result; no scan at cursor end
//   clear              present result, then clear the ceil(DEST_MAX/32) memory
//                      rows (32 at the default) before the next item.
// One item is in flight at a time; item_i.ready is high only when idle.
// Reset: config returns to op_select 0 and dest_size 1024, the cursor goes to
// zero and the memory is cleared by a pass over all ceil(DEST_MAX/32) rows,
// during which no item is taken; APB writes are taken at any time.
// A stalled receiver holds the result in the output register; the engine
// waits with the next result until that one is taken.
module subset_set_operation_engine #(
  parameter int unsigned DEST_MAX = ssoe_pkg::DEST_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  ssoe_in_if.sink                        item_i,
  ssoe_out_if.source                     result_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ssoe_pkg::PADDR_W-1:0]   paddr,
  input  logic [ssoe_pkg::PDATA_W-1:0]   pwdata,
  output logic [ssoe_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int unsigned WW    = ssoe_pkg::WORD_W;
  localparam int unsigned WB    = ssoe_pkg::WORD_BITS_W;
  localparam int unsigned DEPTH = (DEST_MAX + WW - 1) / WW;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEST_MAX + 1);
  localparam int unsigned SW    = (CW > ssoe_pkg::DSIZE_W) ? CW : ssoe_pkg::DSIZE_W;
  localparam int unsigned IW    = AW + WB;
  localparam logic [AW-1:0] LAST_ROW = AW'(DEPTH - 1);

  ssoe_pkg::cfg_t   cfg;
  ssoe_pkg::state_e state_q, state_d;
  ssoe_pkg::kind_e  kind_in;

  logic [CW-1:0]     cursor_q, cursor_d;
  logic [AW-1:0]     word_q, word_d;
  logic [WB-1:0]     bit_q, bit_d;
  logic              is_b_q, is_b_d;
  logic              first_q, first_d;
  logic              clr_q, clr_d;
  logic [AW-1:0]     sweep_q, sweep_d;

  logic [ssoe_pkg::ELEM_W-1:0] pend_elem_q, pend_elem_d;
  logic                        pend_valid_q, pend_valid_d;
  logic                        pend_done_q, pend_done_d;
  ssoe_pkg::err_e              pend_err_q, pend_err_d;

  logic                        out_valid_q, out_valid_d;
  logic [ssoe_pkg::ELEM_W-1:0] out_elem_q;
  logic                        out_evalid_q;
  logic                        out_done_q;
  ssoe_pkg::err_e              out_err_q;
  logic                        out_load;

  logic [2*WW-1:0]   mem_q [DEPTH];
  logic [2*WW-1:0]   rdata_q;
  logic [2*WW-1:0]   mem_wdata;
  logic [AW-1:0]     mem_raddr, mem_waddr;
  logic              mem_re, mem_we;

  logic [SW-1:0]     size_w, last_w, cur_w, val_w;
  logic [CW-1:0]     size_eff;
  logic [AW-1:0]     last_word, cur_word, val_word;
  logic [WB-1:0]     last_bit, cur_bit;
  logic              accept, range_err, cursor_end;

  logic [WW-1:0]     a_word, b_word, sel_word, res_word, cand, lo_mask, hi_mask;
  logic              hit;
  logic [WB-1:0]     enc;
  logic [IW-1:0]     hit_idx;
  logic              resp_free;

  ssoe_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // effective range and scan bounds
  assign size_w    = (SW'(cfg.dest_size) < SW'(DEST_MAX)) ? SW'(cfg.dest_size) : SW'(DEST_MAX);
  assign size_eff  = CW'(size_w);
  assign last_w    = size_w - SW'(1);
  assign last_word = AW'(last_w >> WB);
  assign last_bit  = last_w[WB-1:0];
  assign cur_w     = SW'(cursor_q);
  assign cur_word  = AW'(cur_w >> WB);
  assign cur_bit   = cur_w[WB-1:0];
  assign val_w     = SW'(item_i.value);
  assign val_word  = AW'(val_w >> WB);
  assign range_err = (val_w >= size_w);
  assign cursor_end = (cur_w >= size_w);

  assign kind_in      = ssoe_pkg::kind_e'(item_i.kind);
  assign item_i.ready = (state_q == ssoe_pkg::ST_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign resp_free    = !out_valid_q || result_o.ready;

  // row evaluation
  assign a_word = rdata_q[WW-1:0];
  assign b_word = rdata_q[2*WW-1:WW];
  assign sel_word = is_b_q ? b_word : a_word;

  always_comb begin
    case (cfg.op_select)
      ssoe_pkg::OP_UNION: res_word = a_word | b_word;
      ssoe_pkg::OP_INTER: res_word = a_word & b_word;
      ssoe_pkg::OP_DIFF:  res_word = a_word & ~b_word;
      default:            res_word = ~a_word;
    endcase
  end

  assign lo_mask = first_q ? ~((WW'(1) << cur_bit) - WW'(1)) : '1;
  assign hi_mask = (word_q == last_word) ? ((WW'(2) << last_bit) - WW'(1)) : '1;
  assign cand    = res_word & lo_mask & hi_mask;
  assign hit     = |cand;

  always_comb begin
    enc = '0;
    for (int i = WW - 1; i >= 0; i--) begin
      if (cand[i]) begin
        enc = WB'(i);
      end
    end
  end

  assign hit_idx = {word_q, enc};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssoe_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (kind_in)
            ssoe_pkg::KIND_LOAD_A,
            ssoe_pkg::KIND_LOAD_B: state_d = range_err ? ssoe_pkg::ST_RESP : ssoe_pkg::ST_LOAD;
            ssoe_pkg::KIND_FETCH:  state_d = cursor_end ? ssoe_pkg::ST_RESP : ssoe_pkg::ST_SCAN;
            default:               state_d = ssoe_pkg::ST_RESP;
          endcase
        end
      end
      ssoe_pkg::ST_LOAD: state_d = ssoe_pkg::ST_RESP;
      ssoe_pkg::ST_SCAN: begin
        if (hit || word_q == last_word) begin
          state_d = ssoe_pkg::ST_RESP;
        end
      end
      ssoe_pkg::ST_RESP: begin
        if (resp_free) begin
          state_d = clr_q ? ssoe_pkg::ST_SWEEP : ssoe_pkg::ST_IDLE;
        end
      end
      ssoe_pkg::ST_SWEEP: begin
        if (sweep_q == LAST_ROW) begin
          state_d = ssoe_pkg::ST_IDLE;
        end
      end
      default: state_d = ssoe_pkg::ST_SWEEP;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cursor_d     = cursor_q;
    word_d       = word_q;
    bit_d        = bit_q;
    is_b_d       = is_b_q;
    first_d      = first_q;
    clr_d        = clr_q;
    sweep_d      = sweep_q;
    pend_elem_d  = pend_elem_q;
    pend_valid_d = pend_valid_q;
    pend_done_d  = pend_done_q;
    pend_err_d   = pend_err_q;
    mem_re       = 1'b0;
    mem_raddr    = word_q;
    mem_we       = 1'b0;
    mem_waddr    = word_q;
    mem_wdata    = rdata_q;
    out_load     = 1'b0;
    unique case (state_q)
      ssoe_pkg::ST_IDLE: begin
        if (accept) begin
          pend_elem_d  = '0;
          pend_valid_d = 1'b0;
          pend_done_d  = 1'b0;
          pend_err_d   = ssoe_pkg::ERR_NONE;
          unique case (kind_in)
            ssoe_pkg::KIND_LOAD_A,
            ssoe_pkg::KIND_LOAD_B: begin
              is_b_d = (kind_in == ssoe_pkg::KIND_LOAD_B);
              word_d = val_word;
              bit_d  = val_w[WB-1:0];
              if (range_err) begin
                pend_err_d = ssoe_pkg::ERR_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = val_word;
              end
            end
            ssoe_pkg::KIND_FETCH: begin
              if (cursor_end) begin
                pend_done_d = 1'b1;
              end else begin
                word_d    = cur_word;
                first_d   = 1'b1;
                mem_re    = 1'b1;
                mem_raddr = cur_word;
              end
            end
            default: begin
              cursor_d = '0;
              clr_d    = 1'b1;
            end
          endcase
        end
      end
      ssoe_pkg::ST_LOAD: begin
        if (sel_word[bit_q]) begin
          pend_err_d = ssoe_pkg::ERR_DUP;
        end else begin
          mem_we = 1'b1;
          // B bits sit in the upper half of the row
          mem_wdata[{is_b_q, bit_q}] = 1'b1;
        end
      end
      ssoe_pkg::ST_SCAN: begin
        if (hit) begin
          pend_elem_d  = ssoe_pkg::ELEM_W'(hit_idx);
          pend_valid_d = 1'b1;
          cursor_d     = CW'(SW'(hit_idx) + SW'(1));
        end else if (word_q == last_word) begin
          pend_done_d = 1'b1;
          cursor_d    = size_eff;
        end else begin
          word_d    = word_q + AW'(1);
          first_d   = 1'b0;
          mem_re    = 1'b1;
          mem_raddr = word_q + AW'(1);
        end
      end
      ssoe_pkg::ST_RESP: begin
        if (resp_free) begin
          out_load = 1'b1;
          clr_d    = 1'b0;
        end
      end
      ssoe_pkg::ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = '0;
        sweep_d   = (sweep_q == LAST_ROW) ? '0 : sweep_q + AW'(1);
      end
      default: sweep_d = '0;
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (result_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssoe_pkg::ST_SWEEP;
      cursor_q    <= '0;
      clr_q       <= 1'b0;
      sweep_q     <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      clr_q       <= clr_d;
      sweep_q     <= sweep_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q       <= word_d;
    bit_q        <= bit_d;
    is_b_q       <= is_b_d;
    pend_elem_q  <= pend_elem_d;
    pend_valid_q <= pend_valid_d;
    pend_done_q  <= pend_done_d;
    pend_err_q   <= pend_err_d;
    if (out_load) begin
      out_elem_q   <= pend_elem_q;
      out_evalid_q <= pend_valid_q;
      out_done_q   <= pend_done_q;
      out_err_q    <= pend_err_q;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.element       = out_elem_q;
  assign result_o.element_valid = out_evalid_q;
  assign result_o.done_res      = out_done_q;
  assign result_o.error         = out_err_q;

`ifndef SYNTHESIS
  a_mem_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ssoe_pkg::ST_LOAD || state_q == ssoe_pkg::ST_SWEEP))
    else $error("memory written outside load or clearing pass");

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SW'(cursor_q) <= SW'(DEST_MAX))
    else $error("scan cursor past DEST_MAX");

  a_result_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> !(result_o.element_valid && result_o.done_res)
                       && !(result_o.element_valid && result_o.error != ssoe_pkg::ERR_NONE))
    else $error("inconsistent result flags");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !item_i.ready)
    else $error("second transaction taken while one is in flight");
`endif

endmodule

// ===== test/ssoe_set_checker.sv =====
`timescale 1ns / 1ps
// Channel monitor, set-engine predictor and per-field result comparison.
module ssoe_set_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ssoe_in_if                           item,
  ssoe_out_if                          result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [ssoe_pkg::PADDR_W-1:0] paddr,
  input  logic [ssoe_pkg::PDATA_W-1:0] pwdata,
  output int                           mismatches,
  output int                           outstanding
);

  typedef struct packed {
    logic [ssoe_pkg::ELEM_W-1:0] element;
    logic                        element_valid;
    logic                        done_res;
    ssoe_pkg::err_e              error;
  } outcome_t;

  localparam logic [ssoe_pkg::PADDR_W-1:0] ADDR_OP    =
    ssoe_pkg::PADDR_W'(4 * int'(ssoe_pkg::REG_OP_SELECT));
  localparam logic [ssoe_pkg::PADDR_W-1:0] ADDR_DSIZE =
    ssoe_pkg::PADDR_W'(4 * int'(ssoe_pkg::REG_DEST_SIZE));

  bit [ssoe_pkg::DEST_MAX_DEF-1:0] set_a;
  bit [ssoe_pkg::DEST_MAX_DEF-1:0] set_b;
  int unsigned                     cursor;
  ssoe_pkg::op_e                   op_sel;
  logic [ssoe_pkg::DSIZE_W-1:0]    dsize;
  outcome_t                        outcome_q[$];
  int                              errs = 0;

  assign mismatches = errs;

  function automatic bit selected(input int unsigned i);
    case (op_sel)
      ssoe_pkg::OP_UNION: return set_a[i] | set_b[i];
      ssoe_pkg::OP_INTER: return set_a[i] & set_b[i];
      ssoe_pkg::OP_DIFF:  return set_a[i] & ~set_b[i];
      default:            return ~set_a[i];
    endcase
  endfunction

  function automatic outcome_t apply_item(input ssoe_pkg::kind_e k,
                                         input logic [ssoe_pkg::VALUE_W-1:0] v);
    outcome_t    o;
    int unsigned lim;
    int unsigned i;
    o = '0;
    lim = (dsize < ssoe_pkg::DEST_MAX_DEF) ? dsize : ssoe_pkg::DEST_MAX_DEF;
    case (k)
      ssoe_pkg::KIND_LOAD_A, ssoe_pkg::KIND_LOAD_B: begin
        if (v >= lim) o.error = ssoe_pkg::ERR_RANGE;
        else if ((k == ssoe_pkg::KIND_LOAD_A) ? set_a[v] : set_b[v]) o.error = ssoe_pkg::ERR_DUP;
        else if (k == ssoe_pkg::KIND_LOAD_A) set_a[v] = 1'b1;
        else set_b[v] = 1'b1;
      end
      ssoe_pkg::KIND_FETCH: begin
        i = cursor;
        while (i < lim && !selected(i)) i++;
        if (i < lim) begin
          o.element       = i[ssoe_pkg::ELEM_W-1:0];
          o.element_valid = 1'b1;
          cursor          = i + 1;
        end else begin
          o.done_res = 1'b1;
          if (cursor < lim) cursor = lim;
        end
      end
      default: begin
        set_a  = '0;
        set_b  = '0;
        cursor = 0;
      end
    endcase
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      set_a  = '0;
      set_b  = '0;
      cursor = 0;
      op_sel = ssoe_pkg::OP_UNION;
      dsize  = ssoe_pkg::DSIZE_RST;
      outcome_q.delete();
      outstanding <= 0;
    end else begin
      // results first: a result and a new item can share an edge
      if (result.valid && result.ready) begin
        if (outcome_q.size() == 0) begin
          $error("result transaction with nothing pending");
          errs++;
        end else begin
          want = outcome_q.pop_front();
          check_field("element", 32'(want.element), 32'(result.element));
          check_field("element_valid", 32'(want.element_valid), 32'(result.element_valid));
          check_field("done_res", 32'(want.done_res), 32'(result.done_res));
          check_field("error", 32'(want.error), 32'(result.error));
        end
      end
      if (item.valid && item.ready)
        outcome_q = {outcome_q, apply_item(ssoe_pkg::kind_e'(item.kind), item.value)};
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_OP) op_sel = ssoe_pkg::op_e'(pwdata[ssoe_pkg::OP_W-1:0]);
        else if (paddr == ADDR_DSIZE) dsize = pwdata[ssoe_pkg::DSIZE_W-1:0];
      end
      outstanding <= outcome_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, item stimulus, register writes and the verdict.
module tb;

  localparam int PHASES      = 15;
  localparam int PHASE_ITEMS = 110;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 40;
  localparam int IDLE_LIMIT  = 5000;

  localparam logic [ssoe_pkg::PADDR_W-1:0] ADDR_OP    =
    ssoe_pkg::PADDR_W'(4 * int'(ssoe_pkg::REG_OP_SELECT));
  localparam logic [ssoe_pkg::PADDR_W-1:0] ADDR_DSIZE =
    ssoe_pkg::PADDR_W'(4 * int'(ssoe_pkg::REG_DEST_SIZE));

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [ssoe_pkg::PADDR_W-1:0] paddr;
  logic [ssoe_pkg::PDATA_W-1:0] pwdata;
  logic [ssoe_pkg::PDATA_W-1:0] prdata;
  logic                         pready;
  int                           mismatches;
  int                           outstanding;
  int                           snd_idle = 26;
  int                           rcv_idle = 47;
  int                           sent = 0;
  int                           quiet = 0;
  bit                           hold_req = 1'b0;

  ssoe_in_if  item_if ();
  ssoe_out_if res_if ();

  subset_set_operation_engine dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  ssoe_set_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item        (item_if),
    .result      (res_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk_i = ~clk_i;

  task automatic send_item(input ssoe_pkg::kind_e k, input logic [ssoe_pkg::VALUE_W-1:0] v);
    while ($urandom_range(99) < snd_idle) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.kind  <= k;
    item_if.value <= v;
    do @(posedge clk_i); while (!item_if.ready);
    sent++;
  endtask

  task automatic drain();
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic reg_write(input logic [ssoe_pkg::PADDR_W-1:0] addr,
                           input logic [ssoe_pkg::PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait out the clear sweep too, since it runs on after its result
  task automatic configure(input ssoe_pkg::op_e op, input int unsigned sz);
    drain();
    repeat (SETTLE) @(posedge clk_i);
    reg_write(ADDR_OP, ssoe_pkg::PDATA_W'(op));
    reg_write(ADDR_DSIZE, ssoe_pkg::PDATA_W'(sz));
  endtask

  task automatic build_and_scan(input int unsigned sz);
    int unsigned                  n;
    logic [ssoe_pkg::VALUE_W-1:0] v;
    logic [ssoe_pkg::VALUE_W-1:0] last;
    last = '0;
    n = $urandom_range(12, 1);
    repeat (n) begin
      if ($urandom_range(9) == 0) v = ssoe_pkg::VALUE_W'($urandom_range(1023));
      else if ($urandom_range(6) == 0) v = last;
      else v = ssoe_pkg::VALUE_W'($urandom_range(sz - 1));
      last = v;
      send_item($urandom_range(1) ? ssoe_pkg::KIND_LOAD_B : ssoe_pkg::KIND_LOAD_A, v);
    end
    repeat ($urandom_range(n + 3, 1))
      send_item(ssoe_pkg::KIND_FETCH, ssoe_pkg::VALUE_W'($urandom()));
    if ($urandom_range(1)) send_item(ssoe_pkg::KIND_CLEAR, ssoe_pkg::VALUE_W'($urandom()));
  endtask

  task automatic noise();
    repeat ($urandom_range(5, 1))
      send_item(ssoe_pkg::kind_e'($urandom_range(3)), ssoe_pkg::VALUE_W'($urandom()));
  endtask

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        res_if.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet <= 0;
    end else if (quiet == IDLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int unsigned sz;
    rst_ni        <= 1'b0;
    item_if.valid <= 1'b0;
    item_if.kind  <= ssoe_pkg::KIND_LOAD_A;
    item_if.value <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset config: union over the full range
    send_item(ssoe_pkg::KIND_LOAD_A, 10'd0);
    send_item(ssoe_pkg::KIND_LOAD_A, 10'd1023);
    send_item(ssoe_pkg::KIND_LOAD_A, 10'd0);
    send_item(ssoe_pkg::KIND_LOAD_B, 10'd1023);
    send_item(ssoe_pkg::KIND_LOAD_B, 10'h155);
    send_item(ssoe_pkg::KIND_LOAD_A, 10'h2aa);
    repeat (6) send_item(ssoe_pkg::KIND_FETCH, 10'd0);
    send_item(ssoe_pkg::KIND_CLEAR, 10'h3ff);
    send_item(ssoe_pkg::KIND_FETCH, 10'h3ff);

    // one-element range, complement of A
    configure(ssoe_pkg::OP_COMPL, 1);
    send_item(ssoe_pkg::KIND_LOAD_A, 10'd1);
    send_item(ssoe_pkg::KIND_LOAD_B, 10'd1023);
    repeat (2) send_item(ssoe_pkg::KIND_FETCH, 10'd0);
    send_item(ssoe_pkg::KIND_LOAD_A, 10'd0);
    send_item(ssoe_pkg::KIND_FETCH, 10'd0);
    send_item(ssoe_pkg::KIND_CLEAR, 10'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph / 5)
        0: begin
          snd_idle = 26;
          rcv_idle = 47;
        end
        1: begin
          snd_idle = 47;
          rcv_idle = 26;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase
      case (ph)
        0, 14: sz = ssoe_pkg::DEST_MAX_DEF;
        1: sz = 1;
        2: sz = 2;
        default: begin
          if ($urandom_range(3) == 0) sz = $urandom_range(1024, 65);
          else sz = $urandom_range(64, 3);
        end
      endcase
      // no clear here: the cursor carries over into the new setting
      configure(ssoe_pkg::op_e'(ph % 4), sz);
      if (ph == 7 || ph == 12) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(99) < 80) build_and_scan(sz);
        else noise();
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
